// ===== design/rse_pkg.sv =====
// shared constants and types for the rpn stack evaluator
package rse_pkg;

	localparam int DATA_W        = 32;
	localparam int DEPTH_OUT_W   = 5;
	localparam int STACK_DEPTH_D = 16;

	localparam logic [2:0] OP_PUSH = 3'd0;
	localparam logic [2:0] OP_ADD  = 3'd1;
	localparam logic [2:0] OP_SUB  = 3'd2;
	localparam logic [2:0] OP_MUL  = 3'd3;
	localparam logic [2:0] OP_DIV  = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_UNDER   = 2'd1;
	localparam logic [1:0] ST_OVER    = 2'd2;
	localparam logic [1:0] ST_DIVZERO = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_DIV,
		S_EMIT
	} state_t;

endpackage

// ===== design/rse_ram.sv =====
// generic single-write, single-read ram with registered read data
module rse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/rse_div.sv =====
// iterative signed divider, one quotient bit per cycle, truncates toward zero
module rse_div
	import rse_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] num,
	input  logic [DATA_W-1:0] den,
	output logic              done,
	output logic [DATA_W-1:0] quot
);

	localparam int CW = $clog2(DATA_W);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [DATA_W-1:0] q_q;
	logic [DATA_W-1:0] d_q;
	logic [DATA_W-1:0] rem_q;
	logic              neg_q;
	logic [DATA_W:0]   shifted;
	logic [DATA_W:0]   diff;
	logic              fits;

	always_comb begin
		shifted = {rem_q, q_q[DATA_W-1]};
		diff    = shifted - {1'b0, d_q};
		fits    = !diff[DATA_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// magnitudes in, sign applied on the way out
	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num[DATA_W-1] ? (~num + DATA_W'(1)) : num;
			d_q   <= den[DATA_W-1] ? (~den + DATA_W'(1)) : den;
			rem_q <= '0;
			neg_q <= num[DATA_W-1] ^ den[DATA_W-1];
		end else if (busy_q) begin
			rem_q <= fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
			q_q   <= {q_q[DATA_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = neg_q ? (~q_q + DATA_W'(1)) : q_q;

endmodule

// ===== design/rpn_stack_evaluator_top.sv =====
// rpn stack evaluator: postfix integer tokens on an operand stack held in ram
// push and unused opcodes finish in idle; add, subtract and multiply first read the second
// entry from ram (S_READ); divide then runs the bit-serial divider (S_DIV), which is skipped
// when the divisor is zero; each result passes a pending register, then the output register
// the next beat is taken only once the result has moved to the output register (S_EMIT)
// top of stack is also kept in a register; every entry, top included, is written to the stack ram
// reset clears the stack pointer and control; ram contents are left as they are
module rpn_stack_evaluator_top
	import rse_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_D
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // operand[31:0]
	input  logic [3:0]  s_axis_tuser,   // opcode[2:0], start_req[3]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // top_value[31:0], stack_depth[36:32], zero pad
	output logic [1:0]  m_axis_tuser    // status[1:0]
);

	localparam int PW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	state_t state_q, state_nx;

	logic [PW-1:0]     sp_q, sp_nx, sp_eff;
	logic [PW-1:0]     sp_eff_m2;
	logic [DATA_W-1:0] top_q, top_nx;
	logic [2:0]        op_q;

	logic              we;
	logic [AW-1:0]     waddr;
	logic [DATA_W-1:0] wdata;
	logic [AW-1:0]     raddr;
	logic [DATA_W-1:0] second;

	logic [PW-1:0]     sp_m2;
	logic [2*DATA_W-1:0] prod;
	logic [DATA_W-1:0] alu;
	logic              div_start;
	logic              div_done;
	logic [DATA_W-1:0] div_quot;

	logic              finish;
	logic [1:0]        fin_status;
	logic [PW+DEPTH_OUT_W-1:0] sp_wide;

	logic              pend_valid_q;
	logic [DATA_W-1:0] pend_top_q;
	logic [DEPTH_OUT_W-1:0] pend_depth_q;
	logic [1:0]        pend_status_q;

	logic              out_valid_q;
	logic [DATA_W-1:0] out_top_q;
	logic [DEPTH_OUT_W-1:0] out_depth_q;
	logic [1:0]        out_status_q;
	logic              slot_free;

	logic [2:0]        in_op;
	logic              in_start;

	assign in_op     = s_axis_tuser[2:0];
	assign in_start  = s_axis_tuser[3];
	assign slot_free = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);

	rse_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(second)
	);

	rse_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (second),
		.den   (top_q),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_comb begin
		sp_m2 = sp_q - PW'(2);
		prod  = {{DATA_W{1'b0}}, second} * {{DATA_W{1'b0}}, top_q};
		case (op_q)
			OP_ADD:  alu = second + top_q;
			OP_SUB:  alu = second - top_q;
			default: alu = prod[DATA_W-1:0];
		endcase
	end

	always_comb begin
		state_nx      = state_q;
		sp_nx         = sp_q;
		top_nx        = top_q;
		sp_eff        = in_start ? '0 : sp_q;
		sp_eff_m2     = sp_eff - PW'(2);
		we            = 1'b0;
		waddr         = sp_m2[AW-1:0];
		wdata         = alu;
		raddr         = '0;
		div_start     = 1'b0;
		finish        = 1'b0;
		fin_status    = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				raddr = sp_eff_m2[AW-1:0];
				if (s_axis_tvalid) begin
					sp_nx = sp_eff;
					case (in_op) inside
						OP_PUSH: begin
							finish = 1'b1;
							if (sp_eff >= PW'(STACK_DEPTH)) begin
								fin_status = ST_OVER;
							end else begin
								we     = 1'b1;
								waddr  = sp_eff[AW-1:0];
								wdata  = s_axis_tdata;
								sp_nx  = sp_eff + PW'(1);
								top_nx = s_axis_tdata;
							end
						end
						OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
							if (sp_eff < PW'(2)) begin
								finish     = 1'b1;
								fin_status = ST_UNDER;
							end else begin
								state_nx = S_READ;
							end
						end
						default: finish = 1'b1;
					endcase
				end
			end
			S_READ: begin
				if (op_q == OP_DIV) begin
					if (top_q == '0) begin
						finish     = 1'b1;
						fin_status = ST_DIVZERO;
					end else begin
						div_start = 1'b1;
						state_nx  = S_DIV;
					end
				end else begin
					finish = 1'b1;
					we     = 1'b1;
					sp_nx  = sp_q - PW'(1);
					top_nx = alu;
				end
			end
			S_DIV: begin
				if (div_done) begin
					finish = 1'b1;
					we     = 1'b1;
					wdata  = div_quot;
					sp_nx  = sp_q - PW'(1);
					top_nx = div_quot;
				end
			end
			S_EMIT: begin
				if (slot_free) begin
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
		if (finish) begin
			state_nx = S_EMIT;
		end
		sp_wide = {{DEPTH_OUT_W{1'b0}}, sp_nx};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			sp_q         <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			sp_q    <= sp_nx;
			if (finish) begin
				pend_valid_q <= 1'b1;
			end else if (state_q == S_EMIT && slot_free) begin
				pend_valid_q <= 1'b0;
			end
			if (state_q == S_EMIT && slot_free) begin
				out_valid_q <= pend_valid_q;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		top_q <= top_nx;
		if (state_q == S_IDLE) begin
			op_q <= in_op;
		end
		if (finish) begin
			pend_top_q    <= (sp_nx == '0) ? '0 : top_nx;
			pend_depth_q  <= sp_wide[DEPTH_OUT_W-1:0];
			pend_status_q <= fin_status;
		end
		if (state_q == S_EMIT && slot_free) begin
			out_top_q    <= pend_top_q;
			out_depth_q  <= pend_depth_q;
			out_status_q <= pend_status_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_depth_q, out_top_q};
	assign m_axis_tuser  = out_status_q;

endmodule

// ===== bench/tb.sv =====
// testbench for the rpn stack evaluator: directed and random token streams checked against a local stack model
`timescale 1ns / 100ps

module tb;
	import rse_pkg::*;

	localparam int HOLD_CYCLES  = 400;
	localparam int STUCK_LIMIT  = 4000;
	localparam int TAIL_CYCLES  = 60;
	localparam int RANDOM_TOKENS = 1800;

	// opcodes outside the defined set: no stack operation, but the block still returns a result beat
	localparam logic [2:0] OP_RSVD5 = 3'd5;
	localparam logic [2:0] OP_RSVD6 = 3'd6;
	localparam logic [2:0] OP_RSVD7 = 3'd7;

	typedef struct packed {
		logic [31:0] top;
		logic [4:0]  depth;
		logic [1:0]  status;
	} eval_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;   // operand[31:0]
	logic [3:0]  s_axis_tuser = '0;   // opcode[2:0], start_req[3]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;        // top_value[31:0], stack_depth[36:32], zero pad
	logic [1:0]  m_axis_tuser;        // status[1:0]

	// local copy of the operand stack
	logic [31:0]  model_stack [STACK_DEPTH_D];
	int unsigned  model_sp = 0;
	eval_result_t token_results[$];

	int errors = 0;
	int tokens_sent = 0;
	int gen_depth = 0;
	bit paced = 1'b1;
	int burst_left = 8;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int rx_mode = 0;
	int rx_run = 0;
	int stuck_cycles = 0;

	rpn_stack_evaluator_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] trunc_div(input logic [31:0] num, input logic [31:0] den);
		logic [31:0] mag_n;
		logic [31:0] mag_d;
		logic [31:0] quo;
		mag_n = num[31] ? -num : num;
		mag_d = den[31] ? -den : den;
		quo = mag_n / mag_d;
		return (num[31] ^ den[31]) ? -quo : quo;
	endfunction

	function automatic eval_result_t eval_token(input logic [2:0] op, input logic [31:0] val,
			input logic start);
		eval_result_t res;
		logic [31:0] top;
		logic [31:0] second;
		logic [31:0] value;
		logic [1:0]  st;
		st = ST_OK;
		value = '0;
		if (start)
			model_sp = 0;
		if (op == OP_PUSH) begin
			if (model_sp >= STACK_DEPTH_D) begin
				st = ST_OVER;
			end else begin
				model_stack[model_sp] = val;
				model_sp++;
			end
		end else if (op <= OP_DIV) begin
			if (model_sp < 2) begin
				st = ST_UNDER;
			end else begin
				top = model_stack[model_sp - 1];
				second = model_stack[model_sp - 2];
				case (op)
					OP_ADD: value = second + top;
					OP_SUB: value = second - top;
					OP_MUL: value = second * top;
					default: begin
						if (top == '0)
							st = ST_DIVZERO;
						else
							value = trunc_div(second, top);
					end
				endcase
				if (st == ST_OK) begin
					model_stack[model_sp - 2] = value;
					model_sp--;
				end
			end
		end
		res.top = (model_sp == 0) ? 32'd0 : model_stack[model_sp - 1];
		res.depth = 5'(model_sp);
		res.status = st;
		return res;
	endfunction

	// predict on every accepted input beat
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			token_results.insert(token_results.size(),
				eval_token(s_axis_tuser[2:0], s_axis_tdata, s_axis_tuser[3]));
	end

	// compare every accepted output beat with the oldest prediction
	always @(posedge clk) begin
		eval_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (token_results.size() == 0) begin
				$error("unexpected result beat: top_value %h", m_axis_tdata[31:0]);
				errors++;
			end else begin
				want = token_results.pop_front();
				if (m_axis_tdata[31:0] !== want.top) begin
					$error("top_value: expected %h, got %h", want.top, m_axis_tdata[31:0]);
					errors++;
				end
				if (m_axis_tdata[36:32] !== want.depth) begin
					$error("stack_depth: expected %0d, got %0d", want.depth, m_axis_tdata[36:32]);
					errors++;
				end
				if (m_axis_tuser !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_axis_tuser);
					errors++;
				end
			end
		end
	end

	// receiver: random stall modes, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			if (rx_run == 0) begin
				rx_mode = $urandom_range(0, 2);
				rx_run = $urandom_range(10, 120);
			end
			rx_run--;
			case (rx_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				default: m_axis_tready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_token(input logic [2:0] op, input logic [31:0] val, input logic start);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= val;
		s_axis_tuser <= {start, op};
		do @(posedge clk); while (!s_axis_tready);
		tokens_sent++;
		// rough depth tracking, only used to shape the stimulus
		if (start)
			gen_depth = 0;
		if (op == OP_PUSH) begin
			if (gen_depth < STACK_DEPTH_D)
				gen_depth++;
		end else if (op <= OP_DIV && gen_depth >= 2) begin
			gen_depth--;
		end
		if (paced) begin
			burst_left--;
			if (burst_left <= 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 6)) @(posedge clk);
				burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
			end
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (token_results.size() != 0);
	endtask

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			4, 5: return 32'($urandom_range(0, 40)) - 32'd20;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_arith_wrap();
		send_token(OP_PUSH, 32'h7fff_ffff, 1'b1);
		send_token(OP_PUSH, 32'h0000_0001, 1'b0);
		send_token(OP_ADD, $urandom, 1'b0);
		// most negative over minus one
		send_token(OP_PUSH, 32'hffff_ffff, 1'b0);
		send_token(OP_DIV, $urandom, 1'b0);
		send_token(OP_PUSH, 32'hffff_ffff, 1'b0);
		send_token(OP_MUL, $urandom, 1'b0);
		send_token(OP_PUSH, 32'h0000_0001, 1'b0);
		send_token(OP_SUB, $urandom, 1'b0);
		send_token(OP_PUSH, 32'hffff_fffe, 1'b0);
		send_token(OP_DIV, $urandom, 1'b0);
		send_token(OP_PUSH, 32'h0000_0000, 1'b0);
		send_token(OP_DIV, $urandom, 1'b0);
		drain();
	endtask

	task automatic test_error_cases();
		send_token(OP_ADD, $urandom, 1'b1);
		send_token(OP_PUSH, 32'd9, 1'b0);
		send_token(OP_SUB, $urandom, 1'b0);
		send_token(OP_RSVD7, 32'hffff_ffff, 1'b1);
		send_token(OP_PUSH, 32'd3, 1'b0);
		send_token(OP_RSVD5, $urandom, 1'b0);
		send_token(OP_RSVD6, $urandom, 1'b0);
		send_token(OP_DIV, $urandom, 1'b0);
		send_token(OP_MUL, $urandom, 1'b1);
		drain();
	endtask

	task automatic test_stack_full();
		for (int i = 0; i < STACK_DEPTH_D; i++)
			send_token(OP_PUSH, rand_operand(), (i == 0));
		send_token(OP_PUSH, $urandom, 1'b0);
		send_token(OP_MUL, $urandom, 1'b0);
		drain();
	endtask

	task automatic test_backpressure();
		paced = 1'b0;
		hold_reqs++;
		send_token(OP_PUSH, rand_operand(), 1'b1);
		for (int i = 0; i < 60; i++) begin
			if (gen_depth < 2 || $urandom_range(0, 1) == 0)
				send_token(OP_PUSH, rand_operand(), 1'b0);
			else
				send_token(3'($urandom_range(OP_ADD, OP_DIV)), $urandom, 1'b0);
		end
		paced = 1'b1;
		drain();
	endtask

	task automatic test_random_expressions(input int n_tokens);
		int stop_at;
		int len;
		bit deep;
		logic [2:0] op;
		stop_at = tokens_sent + n_tokens;
		while (tokens_sent < stop_at) begin
			len = $urandom_range(1, 24);
			deep = ($urandom_range(0, 9) == 0);
			send_token(OP_PUSH, rand_operand(), ($urandom_range(0, 3) != 0));
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 7) == 0) begin
					send_token(3'($urandom_range(0, 7)), $urandom, ($urandom_range(0, 15) == 0));
				end else if (gen_depth < 2
						|| (deep && $urandom_range(0, 9) != 0)
						|| (!deep && gen_depth < STACK_DEPTH_D && $urandom_range(0, 99) < 45)) begin
					send_token(OP_PUSH, rand_operand(), 1'b0);
				end else begin
					op = 3'($urandom_range(OP_ADD, OP_DIV));
					send_token(op, $urandom, 1'b0);
				end
			end
			// close the expression down to one value
			while (gen_depth > 1)
				send_token(3'($urandom_range(OP_ADD, OP_DIV)), $urandom, 1'b0);
		end
		drain();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_arith_wrap();
		test_error_cases();
		test_stack_full();
		test_backpressure();
		test_random_expressions(RANDOM_TOKENS);
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && token_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
